@@ design/bssl_pkg.sv @@
// bssl_pkg: request types, status codes and boot script constants for the
// boot script section loader. No dependencies.

package bssl_pkg;

    typedef struct packed {
        logic [31:0] card_word;
        logic        block_first;
        logic        read_good;
        logic        pass_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] load_addr;
        logic [31:0] payload;
        logic        final_word;
    } out_item_t;

    localparam logic [2:0] ST_SEARCH  = 3'd0;
    localparam logic [2:0] ST_HEADER  = 3'd1;
    localparam logic [2:0] ST_PAYLOAD = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_FAIL    = 3'd4;
    localparam logic [2:0] ST_RETRY   = 3'd5;

    localparam logic       CFG_BLOCK_WORDS  = 1'b0;
    localparam logic       CFG_MAX_ATTEMPTS = 1'b1;

    localparam logic [31:0] MAGIC_WORD   = 32'h4150_4954;
    localparam logic [31:0] CMD_SET      = 32'h5853_5907;
    localparam logic [31:0] CMD_FUNCEXEC = 32'h5853_590D;
    localparam logic [31:0] CMD_SECTLOAD = 32'h5853_5901;
    localparam logic [15:0] SET_ARG_WORDS  = 16'd4;
    localparam logic [31:0] BYTES_PER_WORD = 32'd4;

    localparam logic [10:0] BLOCK_WORDS_RESET  = 11'd128;
    localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd4;

endpackage

@@ design/bssl_chan_if.sv @@
// bssl_chan_if: valid/ready channel carrying one request of type T.
// Used with bssl_pkg request types.

interface bssl_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/bssl_in_stage.sv @@
// bssl_in_stage: input request register of the section loader.
// Depends on bssl_pkg.

module bssl_in_stage
    import bssl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/bssl_parser.sv @@
// bssl_parser: boot script parse state, configuration registers and
// result register. Depends on bssl_pkg.

module bssl_parser
    import bssl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_idx,
    input  logic [10:0] cfg_data,
    input  logic      item_valid,
    input  in_item_t  item,
    output logic      take,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam logic [3:0] PH_SEARCH = 4'd0;
    localparam logic [3:0] PH_CMD    = 4'd1;
    localparam logic [3:0] PH_SKIP   = 4'd2;
    localparam logic [3:0] PH_FXARG  = 4'd3;
    localparam logic [3:0] PH_ADDR   = 4'd4;
    localparam logic [3:0] PH_LEN    = 4'd5;
    localparam logic [3:0] PH_PAY    = 4'd6;
    localparam logic [3:0] PH_DONE   = 4'd7;
    localparam logic [3:0] PH_FAIL   = 4'd8;

    logic [10:0] block_words_reg;
    logic [3:0]  max_attempts_reg;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  attempt_reg, attempt_next;
    logic [9:0]  pos_reg, pos_next;
    logic        past_reg, past_next;
    logic [15:0] skip_reg, skip_next;
    logic [31:0] dest_reg, dest_next;
    logic [31:0] entry_reg, entry_next;
    logic [31:0] bytes_reg, bytes_next;
    logic        out_valid_reg;
    out_item_t   out_reg, out_next;

    logic [9:0]  last_pos;
    logic [9:0]  adv_pos;
    logic        adv_past;
    logic [3:0]  att_inc;
    logic        att_fail;
    logic [15:0] skip_dec;
    logic [31:0] bytes_dec;

    assign take = item_valid && (!out_valid_reg || out_ready);

    // last index of the header block, block size clamped to 1..1024
    always_comb
    begin
        if (block_words_reg == 11'd0)
            last_pos = 10'd0;
        else if (block_words_reg[10] && block_words_reg[9:0] != 10'd0)
            last_pos = 10'h3FF;
        else
            last_pos = 10'(block_words_reg - 11'd1);
    end

    always_comb
    begin
        adv_pos  = pos_reg;
        adv_past = past_reg;
        if (!past_reg)
        begin
            if (pos_reg >= last_pos)
                adv_past = 1'b1;
            else
                adv_pos = pos_reg + 10'd1;
        end
    end

    assign att_inc   = (attempt_reg != 4'hF) ? attempt_reg + 4'd1 : attempt_reg;
    assign att_fail  = att_inc >= max_attempts_reg;
    assign skip_dec  = (skip_reg != 16'd0) ? skip_reg - 16'd1 : skip_reg;
    assign bytes_dec = (bytes_reg > BYTES_PER_WORD) ? bytes_reg - BYTES_PER_WORD : 32'd0;

    always_comb
    begin
        phase_next   = phase_reg;
        attempt_next = attempt_reg;
        pos_next     = pos_reg;
        past_next    = past_reg;
        skip_next    = skip_reg;
        dest_next    = dest_reg;
        entry_next   = entry_reg;
        bytes_next   = bytes_reg;
        out_next     = '{status: ST_HEADER, load_addr: 32'd0, payload: 32'd0,
                         final_word: 1'b0};

        if (phase_reg == PH_FAIL)
        begin
            out_next.status = ST_FAIL;
        end
        else if (phase_reg == PH_DONE)
        begin
            out_next.status    = ST_DONE;
            out_next.load_addr = entry_reg;
        end
        else if ((phase_reg == PH_SEARCH && item.pass_end)
                 || (phase_reg != PH_SEARCH && (item.pass_end || !item.read_good))
                 || (phase_reg == PH_CMD && item.card_word != CMD_SET
                     && item.card_word != CMD_FUNCEXEC
                     && item.card_word != CMD_SECTLOAD))
        begin
            attempt_next = att_inc;
            skip_next    = 16'd0;
            bytes_next   = 32'd0;
            pos_next     = 10'd0;
            past_next    = 1'b0;
            if (att_fail)
            begin
                phase_next      = PH_FAIL;
                out_next.status = ST_FAIL;
            end
            else
            begin
                phase_next      = PH_SEARCH;
                out_next.status = ST_RETRY;
            end
        end
        else
        begin
            pos_next  = adv_pos;
            past_next = adv_past;
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (item.block_first && item.read_good && item.card_word == MAGIC_WORD)
                    begin
                        phase_next = PH_CMD;
                        past_next  = (last_pos == 10'd0);
                        pos_next   = (last_pos == 10'd0) ? 10'd0 : 10'd1;
                    end
                    else
                    begin
                        pos_next        = pos_reg;
                        past_next       = past_reg;
                        out_next.status = ST_SEARCH;
                    end
                end
                PH_CMD:
                begin
                    priority if (item.card_word == CMD_SET)
                    begin
                        skip_next  = SET_ARG_WORDS;
                        phase_next = PH_SKIP;
                    end
                    else if (item.card_word == CMD_FUNCEXEC)
                        phase_next = PH_FXARG;
                    else
                        phase_next = PH_ADDR;
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = PH_CMD;
                end
                PH_FXARG:
                begin
                    skip_next  = item.card_word[31:16];
                    phase_next = (item.card_word[31:16] == 16'd0) ? PH_CMD : PH_SKIP;
                end
                PH_ADDR:
                begin
                    dest_next  = item.card_word;
                    entry_next = item.card_word;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    bytes_next = item.card_word;
                    phase_next = (adv_past && item.card_word == 32'd0) ? PH_DONE : PH_PAY;
                end
                PH_PAY:
                begin
                    out_next.status    = ST_PAYLOAD;
                    out_next.load_addr = dest_reg;
                    out_next.payload   = item.card_word;
                    dest_next          = dest_reg + BYTES_PER_WORD;
                    bytes_next         = bytes_dec;
                    if (adv_past && bytes_dec == 32'd0)
                    begin
                        out_next.final_word = 1'b1;
                        phase_next          = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_words_reg  <= BLOCK_WORDS_RESET;
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
            phase_reg        <= PH_SEARCH;
            attempt_reg      <= 4'd0;
            pos_reg          <= 10'd0;
            past_reg         <= 1'b0;
            skip_reg         <= 16'd0;
            dest_reg         <= 32'd0;
            entry_reg        <= 32'd0;
            bytes_reg        <= 32'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_BLOCK_WORDS:  block_words_reg  <= cfg_data;
                    CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[3:0];
                    default:          block_words_reg  <= block_words_reg;
                endcase
            end
            if (take)
            begin
                phase_reg   <= phase_next;
                attempt_reg <= attempt_next;
                pos_reg     <= pos_next;
                past_reg    <= past_next;
                skip_reg    <= skip_next;
                dest_reg    <= dest_next;
                entry_reg   <= entry_next;
                bytes_reg   <= bytes_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ design/boot_script_section_loader.sv @@
// boot_script_section_loader: top level, input register plus parser with
// result register. Depends on bssl_pkg, bssl_chan_if, bssl_in_stage, bssl_parser.
//
//  channel  | dir | payload                                    | accepted when
//  ---------+-----+--------------------------------------------+--------------
//  in_ch    | in  | card_word, block_first, read_good, pass_end | valid && ready
//  out_ch   | out | status, load_addr, payload, final_word      | valid && ready
//  cfg      | in  | cfg_idx, cfg_data                           | cfg_we
//
// One request per cycle sustained while out_ch is ready; a request passes the
// input register, then parse logic into the result register. Reset clears the
// parse state and loads block_words 128, max_attempts 4. A stalled result holds
// while the input register still takes one more request.

module boot_script_section_loader
    import bssl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [10:0] cfg_data,
    bssl_chan_if.sink   in_ch,
    bssl_chan_if.source out_ch
);

    logic     take;
    logic     item_valid;
    in_item_t item;

    bssl_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_data    (in_ch.data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    bssl_parser u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_ch.data)
    );

endmodule

@@ design/bssl_checker.sv @@
// bssl_checker: port-level assertions on the section loader results,
// bound to boot_script_section_loader. Depends on bssl_pkg.

module bssl_checker
    import bssl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    logic done_seen_reg;
    logic fail_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
            fail_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            if (out_data.status == ST_DONE)
                done_seen_reg <= 1'b1;
            if (out_data.status == ST_FAIL)
                fail_seen_reg <= 1'b1;
        end
    end

    a_final_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.final_word |-> out_data.status == ST_PAYLOAD)
        else $error("final_word on a non-payload result");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_PAYLOAD |-> out_data.payload == 32'd0)
        else $error("payload nonzero outside payload results");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_seen_reg |-> out_data.status == ST_DONE)
        else $error("left done state before reset");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fail_seen_reg |-> out_data.status == ST_FAIL)
        else $error("left failed state before reset");

    a_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_SEARCH || out_data.status == ST_HEADER
                      || out_data.status == ST_FAIL || out_data.status == ST_RETRY)
        |-> out_data.load_addr == 32'd0)
        else $error("address on a result that carries none");

endmodule

bind boot_script_section_loader bssl_checker u_bssl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
